@@ rtl/i2cm_pkg.sv @@
`timescale 1ns / 1ps
// i2cm_pkg: shared types and constants of the bit-level I2C master.
// Used by every module in rtl/; depends on nothing.
package i2cm_pkg;

    localparam int ByteW   = 8;
    localparam int OpW     = 3;
    localparam int CmdW    = 3;
    localparam int PhaseW  = 3;
    localparam int BitIdxW = 4;

    localparam int QueueDepth = 2;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCountW    = $clog2(QueueDepth + 1);

    typedef logic [CmdW-1:0]    t_cmd;
    typedef logic [PhaseW-1:0]  t_phase;
    typedef logic [BitIdxW-1:0] t_bit_idx;
    typedef logic [ByteW-1:0]   t_byte;

    // op codes as they arrive on the input word
    localparam logic [OpW-1:0] OP_START = 3'd0;
    localparam logic [OpW-1:0] OP_STOP  = 3'd1;
    localparam logic [OpW-1:0] OP_WRITE = 3'd2;
    localparam logic [OpW-1:0] OP_WAIT  = 3'd3;
    localparam logic [OpW-1:0] OP_READ  = 3'd4;

    // internal command codes (state of the sequencer)
    localparam t_cmd CMD_IDLE  = 3'd0;
    localparam t_cmd CMD_START = 3'd1;
    localparam t_cmd CMD_STOP  = 3'd2;
    localparam t_cmd CMD_WRITE = 3'd3;
    localparam t_cmd CMD_WAIT  = 3'd4;
    localparam t_cmd CMD_READ  = 3'd5;

    localparam t_phase PH_0 = 3'd0;
    localparam t_phase PH_1 = 3'd1;
    localparam t_phase PH_2 = 3'd2;
    localparam t_phase PH_3 = 3'd3;
    localparam t_phase PH_4 = 3'd4;
    localparam t_phase PH_5 = 3'd5;

    localparam t_bit_idx BITS_PER_BYTE = 4'd8;
    localparam t_byte    ACK_LIMIT_RESET = 8'd250;

    // one classified tick, as queued between front and back
    typedef struct packed {
        logic  has_cmd;
        t_cmd  cmd;
        t_byte write_byte;
        logic  send_ack;
        logic  sda_sample;
    } t_entry;

    // queue status toward the back end
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_q_head;

    typedef struct packed {
        logic  scl_level;
        logic  sda_level;
        logic  sda_drive_enable;
        logic  busy_res;
        logic  done_res;
        t_byte read_data;
        logic  ack_failed;
    } t_result;

endpackage

@@ rtl/i2cm_if.sv @@
`timescale 1ns / 1ps
// i2cm_if: valid/ready channel interfaces for tick words and result words.
// Standalone; no package dependency.
interface i2cm_tick_if;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [2:0] op;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_sample;

    modport source (output valid, cmd_valid, op, write_byte, send_ack, sda_sample,
                    input ready);
    modport sink   (input valid, cmd_valid, op, write_byte, send_ack, sda_sample,
                    output ready);
endinterface

interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_failed;

    modport source (output valid, scl_level, sda_level, sda_drive_enable, busy_res,
                    done_res, read_data, ack_failed, input ready);
    modport sink   (input valid, scl_level, sda_level, sda_drive_enable, busy_res,
                    done_res, read_data, ack_failed, output ready);
endinterface

@@ rtl/i2cm_front.sv @@
`timescale 1ns / 1ps
// i2cm_front: accepts tick words and classifies the offered command.
// Depends on i2cm_pkg and i2cm_tick_if.
module i2cm_front (
    i2cm_tick_if.sink       i_tick,
    input  logic            i_q_ready,
    output logic            o_push,
    output i2cm_pkg::t_entry o_entry
);
    import i2cm_pkg::*;

    logic w_known_op;

    assign w_known_op   = (i_tick.op <= OP_READ);
    assign i_tick.ready = i_q_ready;
    assign o_push       = i_tick.valid && i_q_ready;

    always_comb begin
        o_entry.has_cmd    = i_tick.cmd_valid && w_known_op;
        // op codes map one-to-one onto command codes, offset past idle
        o_entry.cmd        = o_entry.has_cmd ? t_cmd'(i_tick.op + 3'd1) : CMD_IDLE;
        o_entry.write_byte = i_tick.write_byte;
        o_entry.send_ack   = i_tick.send_ack;
        o_entry.sda_sample = i_tick.sda_sample;
    end

endmodule

@@ rtl/i2cm_queue.sv @@
`timescale 1ns / 1ps
// i2cm_queue: short FIFO of classified ticks between front and back.
// Depends on i2cm_pkg.
module i2cm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  i2cm_pkg::t_entry i_entry,
    output logic             o_ready,
    input  logic             i_pop,
    output i2cm_pkg::t_q_head o_head
);
    import i2cm_pkg::*;

    t_entry             r_mem [QueueDepth];
    logic [QPtrW-1:0]   r_wr_ptr;
    logic [QPtrW-1:0]   r_rd_ptr;
    logic [QCountW-1:0] r_count;
    logic               w_do_pop;

    assign o_ready      = (r_count != QCountW'(QueueDepth));
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];
    assign w_do_pop     = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPtrW'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPtrW'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/i2cm_back.sv @@
`timescale 1ns / 1ps
// i2cm_back: phase sequencer that drives SCL/SDA, one tick per queued word,
// with the result output register. Depends on i2cm_pkg and i2cm_res_if.
module i2cm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  i2cm_pkg::t_q_head i_head,
    output logic              o_pop,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    i2cm_res_if.source        o_res
);
    import i2cm_pkg::*;

    t_byte    r_limit;
    t_cmd     r_cmd;
    t_phase   r_phase;
    t_bit_idx r_bit;
    t_byte    r_shift;
    t_byte    r_tmo;
    logic     r_ack_choice;
    logic     r_fail;
    logic     r_scl, r_sda, r_drv;
    t_byte    r_rd_data;
    logic     r_out_valid;
    t_result  r_out;

    t_cmd     n_cmd;
    t_phase   n_phase;
    t_bit_idx n_bit;
    t_bit_idx n_bit_inc;
    t_byte    n_shift;
    t_byte    n_tmo;
    logic     n_ack_choice;
    logic     n_fail;
    logic     n_scl, n_sda, n_drv;
    t_byte    n_rd_data;
    logic     n_done;
    t_result  n_out;
    t_entry   w_e;

    assign w_e   = i_head.entry;
    assign o_pop = i_head.valid && (!r_out_valid || o_res.ready);

    always_comb begin
        n_cmd        = r_cmd;
        n_phase      = r_phase;
        n_bit        = r_bit;
        n_shift      = r_shift;
        n_tmo        = r_tmo;
        n_ack_choice = r_ack_choice;
        n_fail       = r_fail;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_drv        = r_drv;
        n_rd_data    = r_rd_data;
        n_done       = 1'b0;
        n_bit_inc    = '0;

        // launch a new command only from idle
        if (r_cmd == CMD_IDLE && w_e.has_cmd) begin
            n_cmd   = w_e.cmd;
            n_phase = PH_0;
            n_bit   = '0;
            if (w_e.cmd == CMD_WRITE) begin
                n_shift = w_e.write_byte;
            end
            if (w_e.cmd == CMD_READ) begin
                n_shift      = '0;
                n_ack_choice = w_e.send_ack;
            end
            if (w_e.cmd == CMD_WAIT) begin
                n_tmo  = '0;
                n_fail = 1'b0;
            end
        end

        n_bit_inc = n_bit + 1'b1;

        unique case (n_cmd)
            CMD_START: begin
                priority case (n_phase)
                    PH_0: begin n_drv = 1'b1; n_sda = 1'b1; n_phase = PH_1; end
                    PH_1: begin n_scl = 1'b1; n_phase = PH_2; end
                    PH_2: begin n_sda = 1'b0; n_phase = PH_3; end
                    default: begin n_scl = 1'b0; n_done = 1'b1; end
                endcase
            end
            CMD_STOP: begin
                priority case (n_phase)
                    PH_0: begin n_drv = 1'b1; n_scl = 1'b0; n_phase = PH_1; end
                    PH_1: begin n_sda = 1'b0; n_phase = PH_2; end
                    PH_2: begin n_scl = 1'b1; n_phase = PH_3; end
                    default: begin n_sda = 1'b1; n_done = 1'b1; end
                endcase
            end
            CMD_WRITE: begin
                priority case (n_phase)
                    PH_0: begin n_drv = 1'b1; n_scl = 1'b0; n_phase = PH_1; end
                    PH_1: begin
                        n_sda   = n_shift[ByteW-1];
                        n_shift = {n_shift[ByteW-2:0], 1'b0};
                        n_phase = PH_2;
                    end
                    PH_2: begin n_scl = 1'b1; n_phase = PH_3; end
                    default: begin
                        n_scl = 1'b0;
                        n_bit = n_bit_inc;
                        if (n_bit_inc >= BITS_PER_BYTE) begin
                            n_done = 1'b1;
                        end else begin
                            n_phase = PH_1;
                        end
                    end
                endcase
            end
            CMD_WAIT: begin
                priority case (n_phase)
                    PH_0: begin n_drv = 1'b0; n_sda = 1'b1; n_phase = PH_1; end
                    PH_1: begin
                        n_scl = 1'b1;
                        if (!w_e.sda_sample) begin
                            n_phase = PH_2;
                        end else if (n_tmo >= r_limit) begin
                            // timeout: flag it and fall into a full stop
                            n_fail  = 1'b1;
                            n_cmd   = CMD_STOP;
                            n_phase = PH_0;
                        end else begin
                            n_tmo = n_tmo + 1'b1;
                        end
                    end
                    default: begin n_scl = 1'b0; n_done = 1'b1; end
                endcase
            end
            CMD_READ: begin
                priority case (n_phase)
                    PH_0: begin n_drv = 1'b0; n_scl = 1'b0; n_phase = PH_1; end
                    PH_1: begin
                        n_scl   = 1'b1;
                        n_shift = {n_shift[ByteW-2:0], w_e.sda_sample};
                        n_bit   = n_bit_inc;
                        n_phase = (n_bit_inc >= BITS_PER_BYTE) ? PH_2 : PH_0;
                    end
                    PH_2: begin n_scl = 1'b0; n_phase = PH_3; end
                    PH_3: begin n_drv = 1'b1; n_sda = !n_ack_choice; n_phase = PH_4; end
                    PH_4: begin n_scl = 1'b1; n_phase = PH_5; end
                    default: begin
                        n_scl     = 1'b0;
                        n_rd_data = n_shift;
                        n_done    = 1'b1;
                    end
                endcase
            end
            default: begin
                n_cmd = CMD_IDLE;
            end
        endcase

        if (n_done) begin
            n_cmd   = CMD_IDLE;
            n_phase = PH_0;
            n_bit   = '0;
        end

        n_out.scl_level        = n_scl;
        n_out.sda_level        = n_sda;
        n_out.sda_drive_enable = n_drv;
        n_out.busy_res         = (n_cmd != CMD_IDLE);
        n_out.done_res         = n_done;
        n_out.read_data        = n_rd_data;
        n_out.ack_failed       = n_fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit      <= ACK_LIMIT_RESET;
            r_cmd        <= CMD_IDLE;
            r_phase      <= PH_0;
            r_bit        <= '0;
            r_shift      <= '0;
            r_tmo        <= '0;
            r_ack_choice <= 1'b0;
            r_fail       <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_drv        <= 1'b1;
            r_rd_data    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (o_pop) begin
                r_cmd        <= n_cmd;
                r_phase      <= n_phase;
                r_bit        <= n_bit;
                r_shift      <= n_shift;
                r_tmo        <= n_tmo;
                r_ack_choice <= n_ack_choice;
                r_fail       <= n_fail;
                r_scl        <= n_scl;
                r_sda        <= n_sda;
                r_drv        <= n_drv;
                r_rd_data    <= n_rd_data;
                r_out_valid  <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.scl_level        = r_out.scl_level;
    assign o_res.sda_level        = r_out.sda_level;
    assign o_res.sda_drive_enable = r_out.sda_drive_enable;
    assign o_res.busy_res         = r_out.busy_res;
    assign o_res.done_res         = r_out.done_res;
    assign o_res.read_data        = r_out.read_data;
    assign o_res.ack_failed       = r_out.ack_failed;

endmodule

@@ rtl/i2c_bit_level_master_top.sv @@
`timescale 1ns / 1ps
// Bit-level I2C master: one tick word in, one result word out.
// A tick word accepted is written into the queue; once the output register is free or
//   taken, one sequencer step puts its result word in the output register.
// Throughput: one word per cycle unless the result side stalls; one phase per word.
// Reset (synchronous, active low): sequencer idle, SCL/SDA high and driven,
//   read byte and failure flag cleared, ack timeout limit 250. Depends on i2cm_pkg.
module i2c_bit_level_master_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    i2cm_tick_if.sink  i_tick,
    i2cm_res_if.source o_res,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);
    import i2cm_pkg::*;

    // front -> queue
    logic    w_push;
    logic    w_q_ready;
    t_entry  w_entry;
    // queue -> back
    t_q_head w_head;
    logic    w_pop;

    // Front: takes a tick word whenever the queue has room and tags whether it
    // carries a legal command (unknown ops fold to "no command").
    i2cm_front u_front (
        .i_tick    (i_tick),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_entry   (w_entry)
    );

    // Two-entry queue so input and output stalls don't couple directly.
    i2cm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    // Back: the phase sequencer. Each popped word advances the bus by one phase
    // and lands a result word in the output register; the limit register lives here.
    i2cm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res       (o_res)
    );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for i2c_bit_level_master_top. It drives tick words and checks
// every result word against a word-by-word model of the bus sequencer kept in this file.
// Depends on rtl/i2cm_pkg.sv, rtl/i2cm_if.sv and rtl/i2c_bit_level_master_top.sv.
module tb;
    import i2cm_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_ITEMS   = 600;
    localparam int QUIET_ITEMS  = 150;  // tail of the random part with no idling
    localparam int DRAIN_GAP    = 4;    // pipeline is two deep, leave some slack
    localparam int END_GAP      = 20;
    localparam int LONG_HOLD    = 60;
    localparam logic [OpW-1:0] OP_TOP = '1;  // highest op code, 5 to 7 are unknown

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    t_byte cfg_wdata;

    i2cm_tick_if tick_bus ();
    i2cm_res_if  res_bus ();

    i2c_bit_level_master_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_tick      (tick_bus),
        .o_res       (res_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bus sequencer model: state after reset, updated once per accepted word
    // ------------------------------------------------------------------
    t_byte    bm_limit  = ACK_LIMIT_RESET;
    t_cmd     bm_cmd    = CMD_IDLE;
    t_phase   bm_phase  = PH_0;
    t_bit_idx bm_bits   = '0;
    t_byte    bm_shift  = '0;
    t_byte    bm_tcnt   = '0;
    logic     bm_ack    = 1'b0;
    logic     bm_fail   = 1'b0;
    logic     bm_scl    = 1'b1;
    logic     bm_sda    = 1'b1;
    logic     bm_drv    = 1'b1;
    t_byte    bm_rdbyte = '0;

    t_result  bus_levels_q[$];   // expected result words, oldest first

    int n_errors  = 0;
    int n_checked = 0;
    int n_ticks   = 0;
    int cycle_cnt = 0;
    int sda_low_pct = 50;        // chance in percent that a sampled SDA bit is low
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    int sink_hold_req = 0;

    function automatic t_result advance_sequencer(input logic cv, input logic [OpW-1:0] op,
                                                  input t_byte wb, input logic sack,
                                                  input logic smp);
        logic    fin;
        t_result r;
        fin = 1'b0;
        // a command is taken only while idle; unknown ops are dropped
        if (bm_cmd == CMD_IDLE && cv && op <= OP_READ) begin
            case (op)
                OP_START: bm_cmd = CMD_START;
                OP_STOP:  bm_cmd = CMD_STOP;
                OP_WRITE: bm_cmd = CMD_WRITE;
                OP_WAIT:  bm_cmd = CMD_WAIT;
                default:  bm_cmd = CMD_READ;
            endcase
            bm_phase = PH_0;
            bm_bits  = '0;
            if (bm_cmd == CMD_WRITE) bm_shift = wb;
            if (bm_cmd == CMD_READ) begin
                bm_shift = '0;
                bm_ack   = sack;
            end
            if (bm_cmd == CMD_WAIT) begin
                bm_tcnt = '0;
                bm_fail = 1'b0;
            end
        end

        case (bm_cmd)
            CMD_START: begin
                case (bm_phase)
                    PH_0: begin bm_drv = 1'b1; bm_sda = 1'b1; bm_phase = PH_1; end
                    PH_1: begin bm_scl = 1'b1; bm_phase = PH_2; end
                    PH_2: begin bm_sda = 1'b0; bm_phase = PH_3; end
                    default: begin bm_scl = 1'b0; fin = 1'b1; end
                endcase
            end
            CMD_STOP: begin
                case (bm_phase)
                    PH_0: begin bm_drv = 1'b1; bm_scl = 1'b0; bm_phase = PH_1; end
                    PH_1: begin bm_sda = 1'b0; bm_phase = PH_2; end
                    PH_2: begin bm_scl = 1'b1; bm_phase = PH_3; end
                    default: begin bm_sda = 1'b1; fin = 1'b1; end
                endcase
            end
            CMD_WRITE: begin
                case (bm_phase)
                    PH_0: begin bm_drv = 1'b1; bm_scl = 1'b0; bm_phase = PH_1; end
                    PH_1: begin
                        bm_sda   = bm_shift[ByteW-1];
                        bm_shift = {bm_shift[ByteW-2:0], 1'b0};
                        bm_phase = PH_2;
                    end
                    PH_2: begin bm_scl = 1'b1; bm_phase = PH_3; end
                    default: begin
                        bm_scl  = 1'b0;
                        bm_bits = bm_bits + 1'b1;
                        if (bm_bits >= BITS_PER_BYTE) fin = 1'b1;
                        else bm_phase = PH_1;
                    end
                endcase
            end
            CMD_WAIT: begin
                case (bm_phase)
                    PH_0: begin bm_drv = 1'b0; bm_sda = 1'b1; bm_phase = PH_1; end
                    PH_1: begin
                        bm_scl = 1'b1;
                        if (!smp) begin
                            bm_phase = PH_2;
                        end else if (bm_tcnt >= bm_limit) begin
                            // timeout: flag it and fall into a full stop sequence
                            bm_fail  = 1'b1;
                            bm_cmd   = CMD_STOP;
                            bm_phase = PH_0;
                        end else begin
                            bm_tcnt = bm_tcnt + 1'b1;
                        end
                    end
                    default: begin bm_scl = 1'b0; fin = 1'b1; end
                endcase
            end
            CMD_READ: begin
                case (bm_phase)
                    PH_0: begin bm_drv = 1'b0; bm_scl = 1'b0; bm_phase = PH_1; end
                    PH_1: begin
                        bm_scl   = 1'b1;
                        bm_shift = {bm_shift[ByteW-2:0], smp};
                        bm_bits  = bm_bits + 1'b1;
                        bm_phase = (bm_bits >= BITS_PER_BYTE) ? PH_2 : PH_0;
                    end
                    PH_2: begin bm_scl = 1'b0; bm_phase = PH_3; end
                    PH_3: begin bm_drv = 1'b1; bm_sda = !bm_ack; bm_phase = PH_4; end
                    PH_4: begin bm_scl = 1'b1; bm_phase = PH_5; end
                    default: begin bm_scl = 1'b0; bm_rdbyte = bm_shift; fin = 1'b1; end
                endcase
            end
            default: bm_cmd = CMD_IDLE;
        endcase

        if (fin) begin
            bm_cmd   = CMD_IDLE;
            bm_phase = PH_0;
            bm_bits  = '0;
        end

        r.scl_level        = bm_scl;
        r.sda_level        = bm_sda;
        r.sda_drive_enable = bm_drv;
        r.busy_res         = (bm_cmd != CMD_IDLE);
        r.done_res         = fin;
        r.read_data        = bm_rdbyte;
        r.ack_failed       = bm_fail;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driving side
    // ------------------------------------------------------------------

    // one tick word; returns in the time step of the edge that took it
    task automatic send_tick(input logic cv, input logic [OpW-1:0] op, input t_byte wb,
                             input logic sack, input logic smp);
        int gap;
        gap = (src_idle_on && $urandom_range(0, 6) == 0) ? $urandom_range(1, 3) : 0;
        if (gap > 0) begin
            tick_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_bus.valid      <= 1'b1;
        tick_bus.cmd_valid  <= cv;
        tick_bus.op         <= op;
        tick_bus.write_byte <= wb;
        tick_bus.send_ack   <= sack;
        tick_bus.sda_sample <= smp;
        do @(posedge clk); while (tick_bus.ready !== 1'b1);
        bus_levels_q.push_back(advance_sequencer(cv, op, wb, sack, smp));
        n_ticks++;
    endtask

    function automatic logic pick_sda();
        return ($urandom_range(0, 99) >= sda_low_pct);
    endfunction

    // offer a command, then keep ticking until the sequencer is idle again;
    // the busy ticks carry random commands that must be ignored
    task automatic run_cmd(input logic [OpW-1:0] op, input t_byte wb, input logic sack);
        send_tick(1'b1, op, wb, sack, pick_sda());
        while (bm_cmd != CMD_IDLE)
            send_tick(1'($urandom_range(0, 1)), OpW'($urandom_range(0, OP_TOP)),
                      t_byte'($urandom), 1'($urandom_range(0, 1)), pick_sda());
    endtask

    // stop offering and let every expected word come back
    task automatic wait_drained();
        tick_bus.valid <= 1'b0;
        while (bus_levels_q.size() != 0) @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic set_ack_limit(input t_byte v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        bm_limit = v;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        $display("mismatch word %0d %s: got %0d want %0d", n_checked, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Result side: ready pattern and checker
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        res_bus.ready <= 1'b1;
        forever begin
            @(posedge clk);
            if (sink_hold_req > 0) begin
                stall_left    = sink_hold_req;
                sink_hold_req = 0;
            end
            if (stall_left > 0) begin
                res_bus.ready <= 1'b0;
                stall_left--;
            end else if (sink_idle_on && $urandom_range(0, 6) == 0) begin
                res_bus.ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        t_result want;
        if (rst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            if (bus_levels_q.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = bus_levels_q.pop_front();
                if (res_bus.scl_level !== want.scl_level)
                    report_mismatch("scl_level", res_bus.scl_level, want.scl_level);
                if (res_bus.sda_level !== want.sda_level)
                    report_mismatch("sda_level", res_bus.sda_level, want.sda_level);
                if (res_bus.sda_drive_enable !== want.sda_drive_enable)
                    report_mismatch("sda_drive_enable", res_bus.sda_drive_enable,
                                    want.sda_drive_enable);
                if (res_bus.busy_res !== want.busy_res)
                    report_mismatch("busy_res", res_bus.busy_res, want.busy_res);
                if (res_bus.done_res !== want.done_res)
                    report_mismatch("done_res", res_bus.done_res, want.done_res);
                if (res_bus.read_data !== want.read_data)
                    report_mismatch("read_data", res_bus.read_data, want.read_data);
                if (res_bus.ack_failed !== want.ack_failed)
                    report_mismatch("ack_failed", res_bus.ack_failed, want.ack_failed);
            end
            n_checked++;
        end
    end

    // hard stop in case the block hangs
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // idle ticks keep the reset levels; unknown ops leave the block idle
    task automatic test_idle_and_unknown();
        int u;
        send_tick(1'b0, OP_START, 8'h00, 1'b0, 1'b0);
        send_tick(1'b0, OP_TOP, 8'hFF, 1'b1, 1'b1);
        for (u = OP_READ + 1; u <= OP_TOP; u++)
            send_tick(1'b1, u[OpW-1:0], t_byte'($urandom), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
    endtask

    task automatic test_start_stop();
        run_cmd(OP_START, '0, 1'b0);
        run_cmd(OP_STOP, '0, 1'b0);
    endtask

    task automatic test_write_extremes();
        run_cmd(OP_START, '0, 1'b0);
        run_cmd(OP_WRITE, 8'h00, 1'b0);
        run_cmd(OP_WRITE, 8'hFF, 1'b0);
        run_cmd(OP_STOP, '0, 1'b0);
    endtask

    // all-zero byte with ACK, all-one byte with NACK, then a mixed one
    task automatic test_read_ack_nack();
        run_cmd(OP_START, '0, 1'b0);
        sda_low_pct = 100;
        run_cmd(OP_READ, '0, 1'b1);
        sda_low_pct = 0;
        run_cmd(OP_READ, '0, 1'b0);
        sda_low_pct = 50;
        run_cmd(OP_READ, '0, 1'b1);
        run_cmd(OP_STOP, '0, 1'b0);
    endtask

    // ack seen at once, timeout with limit zero, timeout at the top limit,
    // and a later wait that clears the failure flag
    task automatic test_wait_ack();
        sda_low_pct = 100;
        run_cmd(OP_WAIT, '0, 1'b0);
        set_ack_limit(8'd0);
        sda_low_pct = 0;
        run_cmd(OP_WAIT, '0, 1'b0);
        set_ack_limit(8'd255);
        run_cmd(OP_WAIT, '0, 1'b0);
        set_ack_limit(8'd3);
        sda_low_pct = 40;
        run_cmd(OP_WAIT, '0, 1'b0);
        sda_low_pct = 100;
        run_cmd(OP_WAIT, '0, 1'b0);
    endtask

    // result side stops for a long stretch while words keep coming, then the
    // sender holds back until everything has drained
    task automatic test_backpressure();
        sda_low_pct   = 50;
        sink_hold_req = LONG_HOLD;
        run_cmd(OP_START, '0, 1'b0);
        run_cmd(OP_WRITE, t_byte'($urandom), 1'b0);
        wait_drained();
        run_cmd(OP_STOP, '0, 1'b0);
    endtask

    task automatic random_session();
        int k;
        sda_low_pct = $urandom_range(20, 95);
        case ($urandom_range(0, 9))
            0: begin
                // ignored words only: no command, or an unknown op
                repeat ($urandom_range(1, 3))
                    send_tick(1'($urandom_range(0, 1)),
                              OpW'($urandom_range(OP_READ + 1, OP_TOP)),
                              t_byte'($urandom), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
            end
            1: begin
                // a stray command out of any transfer
                run_cmd(OpW'($urandom_range(OP_START, OP_READ)), t_byte'($urandom),
                        1'($urandom_range(0, 1)));
            end
            default: begin
                run_cmd(OP_START, '0, 1'b0);
                run_cmd(OP_WRITE, t_byte'($urandom), 1'b0);
                run_cmd(OP_WAIT, '0, 1'b0);
                for (k = 0; k < $urandom_range(1, 2); k++) begin
                    if ($urandom_range(0, 1)) begin
                        run_cmd(OP_WRITE, t_byte'($urandom), 1'b0);
                        run_cmd(OP_WAIT, '0, 1'b0);
                    end else begin
                        run_cmd(OP_READ, '0, 1'($urandom_range(0, 1)));
                    end
                end
                // now and then a repeated start instead of a stop
                if ($urandom_range(0, 3) != 0) run_cmd(OP_STOP, '0, 1'b0);
            end
        endcase
    endtask

    task automatic test_random();
        int first;
        int sessions;
        t_byte lim;
        first    = n_ticks;
        sessions = 0;
        while (n_ticks - first < RAND_ITEMS) begin
            if (n_ticks - first > RAND_ITEMS - QUIET_ITEMS) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            if (sessions % 3 == 0) begin
                case ($urandom_range(0, 9))
                    0:       lim = 8'd0;
                    1:       lim = 8'd255;
                    2:       lim = t_byte'($urandom_range(7, 40));
                    default: lim = t_byte'($urandom_range(1, 6));
                endcase
                set_ack_limit(lim);
            end
            random_session();
            sessions++;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        tick_bus.valid      <= 1'b0;
        tick_bus.cmd_valid  <= 1'b0;
        tick_bus.op         <= OP_START;
        tick_bus.write_byte <= '0;
        tick_bus.send_ack   <= 1'b0;
        tick_bus.sda_sample <= 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_and_unknown();
        test_start_stop();
        test_write_extremes();
        test_read_ack_nack();
        test_wait_ack();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (END_GAP) @(posedge clk);
        if (n_errors == 0 && bus_levels_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
